@@ hw/rtl/cfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpd_pkg: shared types and helpers for the framed packet decoder
// Frame layout constants, verdict codes, the queue entry carried from the
// front end to the back end, and the byte-wide CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package cfpd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [15:0] HEADER_BYTES = 16'd6;
  localparam logic [16:0] MIN_FRAME_BYTES = 17'd8;

  localparam logic [7:0] START_BYTE_RESET = 8'hAA;
  localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd1024;

  // Configuration register indexes
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_PAYLOAD_LIMIT = 1'b1;

  // Result kind carried on the output tuser
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_SHORT_HEADER = 3'd2,
    ERR_OVER_LIMIT = 3'd3,
    ERR_SHORT_PAYLOAD = 3'd4,
    ERR_CRC = 3'd5
  } err_code_t;

  // One accepted byte's worth of work for the back end
  typedef struct packed {
    logic pay_valid;
    logic [7:0] pay_byte;
    logic verdict_valid;
    logic [7:0] frame_type;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
    err_code_t code;
  } q_entry_t;

  // CRC-16/CCITT, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/cfpd_front.sv @@
// ----------------------------------------------------------------------------
// cfpd_front: byte classifier and frame state
// Accepts one byte per transfer, tracks the frame position, updates the
// running CRC, captures header and check fields and queues the results.
// ----------------------------------------------------------------------------
module cfpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                q_full,
  output logic                q_push,
  output cfpd_pkg::q_entry_t  q_data
);
  import cfpd_pkg::*;

  logic [7:0]  start_byte;
  logic [15:0] payload_limit;

  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] running_check, running_check_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_sequence, held_sequence_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] received_check, received_check_next;
  logic        start_matched, start_matched_next;

  logic        accept;
  logic        saturated;
  logic [16:0] pos;
  logic [16:0] pay_end;
  logic [16:0] need_bytes;
  logic [15:0] crc_step;
  logic        pay_valid;
  err_code_t   code;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign saturated = (bytes_seen == COUNT_MAX);
  assign pos = {1'b0, bytes_seen};
  assign pay_end = {1'b0, HEADER_BYTES} + {1'b0, held_length};
  assign crc_step = crc16_byte(running_check, s_tdata);

  // Classify the byte by its place in the frame
  always_comb begin
    bytes_seen_next = bytes_seen;
    running_check_next = running_check;
    held_type_next = held_type;
    held_sequence_next = held_sequence;
    held_length_next = held_length;
    received_check_next = received_check;
    start_matched_next = start_matched;
    pay_valid = 1'b0;
    if (!saturated) begin
      if (bytes_seen == 16'd0) begin
        start_matched_next = (s_tdata == start_byte);
      end else if (bytes_seen < HEADER_BYTES) begin
        case (bytes_seen[2:0])
          3'd1: held_type_next = s_tdata;
          3'd2: held_sequence_next[7:0] = s_tdata;
          3'd3: held_sequence_next[15:8] = s_tdata;
          3'd4: held_length_next[7:0] = s_tdata;
          default: held_length_next[15:8] = s_tdata;
        endcase
        running_check_next = crc_step;
      end else if (pos < pay_end) begin
        running_check_next = crc_step;
        pay_valid = start_matched && (held_length <= payload_limit);
      end else if (pos == pay_end) begin
        received_check_next[7:0] = s_tdata;
      end else if (pos == pay_end + 17'd1) begin
        received_check_next[15:8] = s_tdata;
      end
      bytes_seen_next = bytes_seen + 16'd1;
    end
  end

  // Verdict in order of precedence, on the updated frame state
  assign need_bytes = MIN_FRAME_BYTES + {1'b0, held_length_next};

  always_comb begin
    if (!start_matched_next) begin
      code = ERR_BAD_START;
    end else if ({1'b0, bytes_seen_next} < MIN_FRAME_BYTES) begin
      code = ERR_SHORT_HEADER;
    end else if (held_length_next > payload_limit) begin
      code = ERR_OVER_LIMIT;
    end else if ({1'b0, bytes_seen_next} < need_bytes) begin
      code = ERR_SHORT_PAYLOAD;
    end else if (received_check_next != running_check_next) begin
      code = ERR_CRC;
    end else begin
      code = ERR_NONE;
    end
  end

  // Queue entry for the back end
  always_comb begin
    q_data.pay_valid = pay_valid;
    q_data.pay_byte = s_tdata;
    q_data.verdict_valid = s_tlast;
    q_data.frame_type = held_type_next;
    q_data.sequence_number = held_sequence_next;
    q_data.payload_length = held_length_next;
    q_data.code = code;
  end

  assign q_push = accept && (pay_valid || s_tlast);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      payload_limit <= PAYLOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte <= cfg_data[7:0];
        CFG_PAYLOAD_LIMIT: payload_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance frame state; clear it after the final byte of a buffer
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      bytes_seen <= 16'd0;
      running_check <= CRC_INIT;
      held_type <= 8'd0;
      held_sequence <= 16'd0;
      held_length <= 16'd0;
      received_check <= 16'd0;
      start_matched <= 1'b0;
    end else if (accept) begin
      bytes_seen <= bytes_seen_next;
      running_check <= running_check_next;
      held_type <= held_type_next;
      held_sequence <= held_sequence_next;
      held_length <= held_length_next;
      received_check <= received_check_next;
      start_matched <= start_matched_next;
    end
  end

endmodule

@@ hw/rtl/cfpd_fifo.sv @@
// ----------------------------------------------------------------------------
// cfpd_fifo: short queue between the front end and the back end
// Register-based FIFO; head entry is presented combinationally.
// ----------------------------------------------------------------------------
module cfpd_fifo #(
  parameter int unsigned DEPTH = cfpd_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cfpd_pkg::q_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output cfpd_pkg::q_entry_t  pop_data,
  output logic                empty
);
  import cfpd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  q_entry_t        slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full = (count == FullCount);
  assign empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FullCount)
    else $error("queue occupancy out of range");
`endif

endmodule

@@ hw/rtl/cfpd_back.sv @@
// ----------------------------------------------------------------------------
// cfpd_back: result sequencer and output register
// Expands each queue entry into a payload result, a verdict result or both,
// one per transfer, through a registered output stage.
// ----------------------------------------------------------------------------
module cfpd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cfpd_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,
  output logic [0:0]          m_tuser,
  output logic                m_tlast
);
  import cfpd_pkg::*;

  logic        pay_done;
  logic        load;
  logic        emit_pay;
  logic [7:0]  out_pay_byte;
  logic [7:0]  out_frame_type;
  logic [15:0] out_sequence;
  logic [15:0] out_length;
  logic        out_ok;
  err_code_t   out_code;

  assign load = !m_tvalid || m_tready;
  assign emit_pay = q_head.pay_valid && !pay_done;
  // Hold the entry after its payload result when a verdict is still owed
  assign q_pop = load && !q_empty && !(emit_pay && q_head.verdict_valid);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pay_done <= 1'b0;
    end else if (load) begin
      m_tvalid <= !q_empty;
      if (!q_empty) begin
        if (emit_pay) begin
          pay_done <= q_head.verdict_valid;
        end else begin
          pay_done <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (emit_pay) begin
        m_tuser <= KIND_PAYLOAD;
        m_tlast <= !q_head.verdict_valid;
        out_pay_byte <= q_head.pay_byte;
        out_frame_type <= 8'd0;
        out_sequence <= 16'd0;
        out_length <= 16'd0;
        out_ok <= 1'b0;
        out_code <= ERR_NONE;
      end else begin
        m_tuser <= KIND_VERDICT;
        m_tlast <= 1'b1;
        out_pay_byte <= 8'd0;
        out_frame_type <= q_head.frame_type;
        out_sequence <= q_head.sequence_number;
        out_length <= q_head.payload_length;
        out_ok <= (q_head.code == ERR_NONE);
        out_code <= q_head.code;
      end
    end
  end

  assign m_tdata = {4'd0, out_code, out_ok, out_length, out_sequence, out_frame_type,
                    out_pay_byte};

`ifndef SYNTH
  a_pending_verdict: assert property (@(posedge clk) disable iff (rst)
    pay_done |-> !q_empty && q_head.verdict_valid)
    else $error("payload sent but no verdict pending");
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_VERDICT) |-> m_tlast)
    else $error("verdict not marked last");
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_ok == ((m_tuser == KIND_VERDICT) && (out_code == ERR_NONE))))
    else $error("frame_ok disagrees with error code");
`endif

endmodule

@@ hw/rtl/crc_framed_packet_decoder_core.sv @@
// ----------------------------------------------------------------------------
// crc_framed_packet_decoder_core: CRC-16 checked frame deframer
// Byte-serial frame checker: front end, result queue and output sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_ stream, one byte per transfer, with
//   s_tlast on the final byte of a buffer. Results leave on the m_ stream:
//   m_tuser says whether a transfer is a payload byte or a frame verdict,
//   m_tlast marks the final result caused by one input byte.
//   The cfg_ port writes the start byte (index 0) and the payload limit
//   (index 1); write only while no frame is in progress.
// Timing:
//   One byte is taken every cycle while the queue is not full; the CRC is
//   updated a whole byte per cycle in the front end. A result passes through
//   a queue slot and the output register after the byte's transfer. A final byte
//   that is also a payload byte yields two results, which the queue absorbs.
// Reset and stalls:
//   rst clears the frame state, the queue and the output stage, and loads
//   the register defaults (start byte AAh, payload limit 1024). When m_tready
//   is low the output holds; the queue fills and s_tready falls when full.
// ----------------------------------------------------------------------------
module crc_framed_packet_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = cfpd_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] payload_byte, [15:8] frame_type,
                                 // [31:16] sequence_number, [47:32] payload_length,
                                 // [48] frame_ok, [51:49] error_code, [55:52] zero
  output logic [0:0]  m_tuser,   // [0] kind
  output logic        m_tlast
);
  import cfpd_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_in;
  q_entry_t q_head;

  // Classify bytes and keep frame state
  cfpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Decouple front and back
  cfpd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_head),
    .empty    (q_empty)
  );

  // Sequence results onto the output stream
  cfpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the CRC-16 checked frame deframer
// Drives received buffers into the byte stream with random gaps and output
// stalls, predicts every payload and verdict transfer from a bit-level model
// of the frame checker, and compares each result field by field. Runs a
// short directed set and random frames under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import cfpd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 250;
  localparam logic [16:0] HEADER_END = 17'd6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_START_BYTE;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  int unsigned sent_bytes = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  frame_bytes[$];

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    logic [7:0]  ftype;
    logic [15:0] seq;
    logic [15:0] len;
    logic        ok;
    err_code_t   code;
    logic        last;
  } deframe_result_t;

  // CRC-16/CCITT, one message bit at a time, MSB first
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                 input logic [7:0] octet);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ octet[k];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  // Frame checker model plus the queue of results it still awaits
  class deframe_predictor;
    logic [7:0]      start_sel;
    logic [15:0]     limit;
    logic [15:0]     seen;
    logic [15:0]     crc_acc;
    logic [15:0]     crc_rx;
    logic [15:0]     seq_hold;
    logic [15:0]     len_hold;
    logic [7:0]      type_hold;
    logic            start_ok;
    deframe_result_t awaited[$];
    int unsigned     fails;

    function new();
      start_sel = START_BYTE_RESET;
      limit = PAYLOAD_LIMIT_RESET;
      fails = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      seen = '0;
      crc_acc = CRC_INIT;
      crc_rx = '0;
      seq_hold = '0;
      len_hold = '0;
      type_hold = '0;
      start_ok = 1'b0;
    endfunction

    function void set_reg(input logic idx, input logic [15:0] value);
      if (idx == CFG_START_BYTE) start_sel = value[7:0];
      else limit = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Advance the frame state by one accepted byte and queue its results
    function void take_byte(input logic [7:0] b, input logic l);
      logic [16:0]     pos;
      logic [16:0]     pay_end;
      logic            pay_out;
      err_code_t       code;
      deframe_result_t r;
      pay_out = 1'b0;
      // a byte arriving on a saturated count is dropped, but its end mark counts
      if (seen != COUNT_MAX) begin
        pos = {1'b0, seen};
        pay_end = HEADER_END + {1'b0, len_hold};
        if (pos == 17'd0) begin
          start_ok = (b == start_sel);
        end else if (pos < HEADER_END) begin
          case (pos)
            17'd1: type_hold = b;
            17'd2: seq_hold[7:0] = b;
            17'd3: seq_hold[15:8] = b;
            17'd4: len_hold[7:0] = b;
            default: len_hold[15:8] = b;
          endcase
          crc_acc = crc_ccitt_step(crc_acc, b);
        end else if (pos < pay_end) begin
          crc_acc = crc_ccitt_step(crc_acc, b);
          pay_out = start_ok && (len_hold <= limit);
        end else if (pos == pay_end) begin
          crc_rx[7:0] = b;
        end else if (pos == pay_end + 17'd1) begin
          crc_rx[15:8] = b;
        end
        seen = seen + 16'd1;
      end
      // payload transfer goes ahead of the verdict of the same byte
      if (pay_out) begin
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.pay = b;
        r.last = !l;
        awaited.push_back(r);
      end
      if (l) begin
        if (!start_ok) code = ERR_BAD_START;
        else if ({1'b0, seen} < MIN_FRAME_BYTES) code = ERR_SHORT_HEADER;
        else if (len_hold > limit) code = ERR_OVER_LIMIT;
        else if ({1'b0, seen} < MIN_FRAME_BYTES + {1'b0, len_hold}) code = ERR_SHORT_PAYLOAD;
        else if (crc_rx != crc_acc) code = ERR_CRC;
        else code = ERR_NONE;
        r = '0;
        r.kind = KIND_VERDICT;
        r.ftype = type_hold;
        r.seq = seq_hold;
        r.len = len_hold;
        r.ok = (code == ERR_NONE);
        r.code = code;
        r.last = 1'b1;
        awaited.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
        fails++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // Compare one output transfer with the oldest awaited result
    function void match_result(input logic [55:0] td, input logic kind, input logic lst);
      deframe_result_t w;
      if (awaited.size() == 0) begin
        fails++;
        $error("result with nothing awaited: tdata %0h kind %0b", td, kind);
        return;
      end
      w = awaited.pop_front();
      check_field("kind", 16'(w.kind), 16'(kind));
      check_field("payload_byte", 16'(w.pay), 16'(td[7:0]));
      check_field("frame_type", 16'(w.ftype), 16'(td[15:8]));
      check_field("sequence_number", w.seq, td[31:16]);
      check_field("payload_length", w.len, td[47:32]);
      check_field("frame_ok", 16'(w.ok), 16'(td[48]));
      check_field("error_code", 16'(w.code), 16'(td[51:49]));
      check_field("tdata pad", 16'h0000, 16'(td[55:52]));
      check_field("last_of_run", 16'(w.last), 16'(lst));
    endfunction
  endclass

  deframe_predictor sb;

  crc_framed_packet_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_result(m_tdata, m_tuser[0], m_tlast);
  end

  // Abort when neither side has moved a transfer for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Output side: random stall ahead of each result
  initial begin : result_sink
    int unsigned gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one byte after a random gap; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_byte(b, l);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Send the first cut bytes of the built frame; hold off until drained at pause_at
  task automatic send_buffer(input int cut, input int pause_at);
    for (int i = 0; i < cut; i++) begin
      if (i == pause_at) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      send_byte(frame_bytes[i], i == cut - 1);
    end
  endtask

  // Write one register with no frame in progress and the output drained
  task automatic write_reg(input logic idx, input logic [15:0] value);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Assemble header, payload, check (xored with crc_mask) and trailing bytes
  function automatic void build_frame(input logic [7:0] lead, input logic [7:0] ftype,
                                      input logic [15:0] seq, input logic [15:0] len_field,
                                      input int unsigned pay_count,
                                      input logic [15:0] crc_mask,
                                      input int unsigned trailing);
    logic [15:0] acc;
    frame_bytes.delete();
    frame_bytes.push_back(lead);
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(seq[7:0]);
    frame_bytes.push_back(seq[15:8]);
    frame_bytes.push_back(len_field[7:0]);
    frame_bytes.push_back(len_field[15:8]);
    repeat (pay_count) frame_bytes.push_back(8'($urandom));
    acc = CRC_INIT;
    for (int i = 1; i < frame_bytes.size(); i++) acc = crc_ccitt_step(acc, frame_bytes[i]);
    acc = acc ^ crc_mask;
    frame_bytes.push_back(acc[7:0]);
    frame_bytes.push_back(acc[15:8]);
    repeat (trailing) frame_bytes.push_back(8'($urandom));
  endfunction

  // One random buffer: mostly good frames, plus broken ones and noise
  task automatic random_buffer();
    int unsigned pick;
    int unsigned len_cap;
    int unsigned len;
    int unsigned count;
    int unsigned trailing;
    int          cut;
    int          pause_at;
    logic [7:0]  lead;
    logic [15:0] mask;
    tx_idle_on = ($urandom_range(0, 5) != 0);
    rx_idle_on = ($urandom_range(0, 5) != 0);
    pick = $urandom_range(0, 99);
    len_cap = (sb.limit < 16'd12) ? sb.limit : 12;
    if ($urandom_range(0, 9) == 0) len_cap = (sb.limit < 16'd60) ? sb.limit : 60;
    len = $urandom_range(0, len_cap);
    lead = sb.start_sel;
    mask = 16'h0000;
    trailing = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    if (pick >= 92) begin
      // noise with stray end marks
      count = $urandom_range(1, 20);
      for (int i = 0; i < count; i++) begin
        send_byte(8'($urandom), (i == count - 1) || ($urandom_range(0, 7) == 0));
      end
    end else begin
      if (pick >= 55 && pick < 67) mask = 16'($urandom_range(1, 16'hFFFF));
      if (pick >= 77 && pick < 84) lead = lead ^ 8'($urandom_range(1, 255));
      if (pick >= 84) begin
        // length field above the limit, only a few bytes after it
        build_frame(lead, 8'($urandom), 16'($urandom),
                    16'(sb.limit + $urandom_range(1, 8)), $urandom_range(0, 10), 16'h0000,
                    trailing);
      end else begin
        build_frame(lead, 8'($urandom), 16'($urandom), 16'(len), len, mask, trailing);
      end
      cut = frame_bytes.size();
      if (pick >= 67 && pick < 77) cut = $urandom_range(1, frame_bytes.size() - 1);
      pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cut - 1) : -1;
      send_buffer(cut, pause_at);
    end
  endtask

  task automatic random_phase(input int unsigned byte_goal);
    int unsigned goal;
    goal = sent_bytes + byte_goal;
    while (sent_bytes < goal) random_buffer();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: good frame with a trailing byte, pausing before its check bytes
    build_frame(START_BYTE_RESET, 8'hFF, 16'h0000, 16'd1, 1, 16'h0000, 1);
    send_buffer(frame_bytes.size(), 7);
    // bad start on a single byte
    frame_bytes = '{8'h00};
    send_buffer(1, -1);
    // short header
    frame_bytes = '{START_BYTE_RESET, 8'h00};
    send_buffer(2, -1);
    // length over the limit
    build_frame(START_BYTE_RESET, 8'h00, 16'hFFFF, 16'hFFFF, 2, 16'h0000, 0);
    send_buffer(8, -1);
    // short payload ending on a payload byte: payload then verdict
    build_frame(START_BYTE_RESET, 8'h5A, 16'h1234, 16'd3, 3, 16'h0000, 0);
    send_buffer(8, -1);
    // check mismatch on an empty payload
    build_frame(START_BYTE_RESET, 8'hA5, 16'h8001, 16'd0, 0, 16'h8000, 0);
    send_buffer(frame_bytes.size(), -1);

    // Random frames under the reset settings
    random_phase(PHASE_BYTES);

    // Smallest start byte and limit
    write_reg(CFG_START_BYTE, 16'h0000);
    write_reg(CFG_PAYLOAD_LIMIT, 16'h0000);
    random_phase(PHASE_BYTES);

    // Largest start byte and a limit of FFF7h
    write_reg(CFG_START_BYTE, 16'h00FF);
    write_reg(CFG_PAYLOAD_LIMIT, 16'hFFF7);
    random_phase(PHASE_BYTES);

    // Random start byte and a small limit
    write_reg(CFG_START_BYTE, 16'($urandom_range(0, 255)));
    write_reg(CFG_PAYLOAD_LIMIT, 16'($urandom_range(8, 40)));
    random_phase(PHASE_BYTES);

    // Drain and let the pipeline settle
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cfpd_pkg.sv
hw/rtl/cfpd_front.sv
hw/rtl/cfpd_fifo.sv
hw/rtl/cfpd_back.sv
hw/rtl/crc_framed_packet_decoder_core.sv
tb/tb.sv
